@@ hdl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is held
`define U8W_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8w check failed");

// clocked check, also active during reset
`define U8W_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("u8w check failed");

`else

`define U8W_ASSERT(lbl, clk, rst_n, prop)
`define U8W_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

@@ hdl/u8w_pkg.sv @@
package u8w_pkg;

    localparam int CODE_W = 21;
    localparam int UNIT_W = 16;

    // register map, index is paddr[2]
    localparam logic REG_WIDE_MODE = 1'b0;
    localparam logic REG_REPL_CHAR = 1'b1;

    localparam logic [UNIT_W-1:0] REPL_RESET = 16'h003F;

    localparam logic [CODE_W-1:0] SURR_MASK  = 21'h1FF800;
    localparam logic [CODE_W-1:0] SURR_BASE  = 21'h00D800;
    localparam logic [CODE_W-1:0] PLANE1     = 21'h010000;

    // input beat
    typedef struct packed {
        logic [7:0] byte_in;
        logic       string_end;
    } t_in;

    // output beat
    typedef struct packed {
        logic [CODE_W-1:0] code_unit;
        logic              last_unit;
    } t_out;

    // how a finished code point is to be emitted
    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_REPL = 2'd1,
        KIND_PAIR = 2'd2
    } t_kind;

    // entry of the queue between front and back
    typedef struct packed {
        t_kind             kind;
        logic [CODE_W-1:0] cp;
    } t_evt;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ hdl/utf8_to_wide_decoder.sv @@
// UTF-8 byte stream to UTF-16 / UTF-32 code unit decoder. One byte is accepted per
// clock while the internal queue has room; the output register delivers one code unit
// per clock while the receiver is ready, so a code point that becomes a surrogate pair
// in 16-bit mode is sent as a high unit and then a low unit, and is the only case that
// slows the stream. An accepted byte that completes a code point is pushed by the front
// decode into the queue; the queue head is then loaded into the output register.
// The queue of QUEUE_DEPTH entries lets the byte side keep running while the unit
// side stalls. Registers: 0x0 wide_mode (bit 0), 0x4 replacement_char (bits 15:0),
// both readable; write them only while the block is idle.
`include "assert_macros.svh"

module utf8_to_wide_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  u8w_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output u8w_pkg::t_out  o_out,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);
    import u8w_pkg::*;

    logic        r_wide_mode;
    logic [15:0] r_repl_char;
    logic        cfg_wr;
    logic        push;
    logic        pop;
    t_evt        evt_in;
    t_evt        evt_head;
    t_qstat      qstat;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= 1'b0;
            r_repl_char <= REPL_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_WIDE_MODE) begin
                r_wide_mode <= pwdata[0];
            end else begin
                r_repl_char <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_REPL_CHAR) begin
            prdata = {16'd0, r_repl_char};
        end else begin
            prdata = {31'd0, r_wide_mode};
        end
    end

    // byte side
    u8w_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wide_mode (r_wide_mode),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_evt       (evt_in)
    );

    // decoupling queue
    u8w_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (evt_in),
        .i_pop   (pop),
        .o_evt   (evt_head),
        .o_qstat (qstat)
    );

    // unit side
    u8w_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_repl_char (r_repl_char),
        .i_evt       (evt_head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // checks
    `U8W_ASSERT(a_no_push_full, i_clk, i_rst_n, push |-> !qstat.full)
    `U8W_ASSERT(a_no_pop_empty, i_clk, i_rst_n, pop |-> !qstat.empty)
    `U8W_ASSERT(a_pair_low_follows, i_clk, i_rst_n, (o_out_valid && i_out_ready && !o_out.last_unit) |=> (o_out_valid && o_out.last_unit))

endmodule

@@ hdl/u8w_front.sv @@
module u8w_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wide_mode,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  u8w_pkg::t_in   i_in,
    input  u8w_pkg::t_qstat i_qstat,
    output logic           o_push,
    output u8w_pkg::t_evt  o_evt
);
    import u8w_pkg::*;

    logic [CODE_W-1:0] r_pc, n_pc;
    logic [1:0]        r_rem, n_rem;
    logic              r_skip, n_skip;

    logic [7:0]        b;
    logic              is_cont;
    logic              take;
    logic              emit;
    logic [CODE_W-1:0] ecp;
    logic [CODE_W-1:0] cont_pc;
    logic              accept;

    // lead byte decode
    logic              l_emit;
    logic              l_skip;
    logic              l_start;
    logic [CODE_W-1:0] l_pc;
    logic [1:0]        l_rem;

    assign b          = i_in.byte_in;
    assign is_cont    = (b[7:6] == 2'b10);
    assign cont_pc    = {r_pc[CODE_W-7:0], b[5:0]};
    assign o_in_ready = !i_qstat.full;
    assign accept     = i_in_valid && o_in_ready;

    // classify a byte taken as a lead
    always_comb begin
        l_emit  = 1'b0;
        l_skip  = 1'b0;
        l_start = 1'b0;
        l_pc    = '0;
        l_rem   = 2'd0;
        if (b[7] == 1'b0) begin
            l_emit = 1'b1;
        end else if (b[6] == 1'b0) begin
            l_skip = 1'b1;
        end else if (b[5] == 1'b0) begin
            l_start = 1'b1;
            l_pc    = {{(CODE_W-5){1'b0}}, b[4:0]};
            l_rem   = 2'd1;
        end else if (b[4] == 1'b0) begin
            l_start = 1'b1;
            l_pc    = {{(CODE_W-4){1'b0}}, b[3:0]};
            l_rem   = 2'd2;
        end else if (b[3] == 1'b0) begin
            l_start = 1'b1;
            l_pc    = {{(CODE_W-3){1'b0}}, b[2:0]};
            l_rem   = 2'd3;
        end else begin
            l_skip = 1'b1;
        end
    end

    // sequence tracking
    always_comb begin
        n_pc   = r_pc;
        n_rem  = r_rem;
        n_skip = r_skip;
        take   = 1'b0;
        emit   = 1'b0;
        ecp    = '0;
        if (r_skip) begin
            if (!is_cont) begin
                n_skip = 1'b0;
                take   = 1'b1;
            end
        end else if (r_rem != 2'd0) begin
            if (is_cont) begin
                n_pc  = cont_pc;
                n_rem = r_rem - 2'd1;
                if (r_rem == 2'd1) begin
                    emit = 1'b1;
                    ecp  = cont_pc;
                    n_pc = '0;
                end
            end else begin
                // broken sequence, restart on this byte
                n_pc  = '0;
                n_rem = 2'd0;
                take  = 1'b1;
            end
        end else begin
            take = 1'b1;
        end

        if (take) begin
            if (l_emit) begin
                emit = 1'b1;
                ecp  = {{(CODE_W-8){1'b0}}, b};
            end
            if (l_skip) begin
                n_skip = 1'b1;
            end
            if (l_start) begin
                n_pc  = l_pc;
                n_rem = l_rem;
            end
        end

        // end of string drops any open sequence
        if (i_in.string_end) begin
            n_pc   = '0;
            n_rem  = 2'd0;
            n_skip = 1'b0;
        end
    end

    // emission kind of the finished code point
    always_comb begin
        o_evt.cp = ecp;
        if ((ecp & SURR_MASK) == SURR_BASE) begin
            o_evt.kind = KIND_REPL;
        end else if (ecp < PLANE1 || i_wide_mode) begin
            o_evt.kind = KIND_UNIT;
        end else begin
            o_evt.kind = KIND_PAIR;
        end
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_rem  <= 2'd0;
            r_skip <= 1'b0;
        end else if (accept) begin
            r_pc   <= n_pc;
            r_rem  <= n_rem;
            r_skip <= n_skip;
        end
    end

endmodule

@@ hdl/u8w_queue.sv @@
module u8w_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8w_pkg::t_evt   i_evt,
    input  logic            i_pop,
    output u8w_pkg::t_evt   o_evt,
    output u8w_pkg::t_qstat o_qstat
);
    import u8w_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_evt          r_mem [DEPTH];
    logic [AW-1:0] r_wp, n_wp;
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_qstat.full  = (r_cnt == FULL);
    assign o_qstat.empty = (r_cnt == '0);
    assign o_evt         = r_mem[r_rp];

    // pointer and fill count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + AW'(1);
        end
        if (i_pop) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_evt;
        end
    end

endmodule

@@ hdl/u8w_back.sv @@
module u8w_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [15:0]     i_repl_char,
    input  u8w_pkg::t_evt   i_evt,
    input  u8w_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output u8w_pkg::t_out   o_out
);
    import u8w_pkg::*;

    logic              r_valid;
    logic              r_second;
    t_out              r_out;
    logic              n_second;
    t_out              n_out;
    logic              load;
    logic              first_half;
    logic [CODE_W-1:0] v;
    logic [UNIT_W-1:0] hi_unit;
    logic [UNIT_W-1:0] lo_unit;

    assign load       = !r_valid || i_out_ready;
    assign first_half = (i_evt.kind == KIND_PAIR) && !r_second;
    assign o_pop      = load && !i_qstat.empty && !first_half;

    // surrogate pair halves
    assign v       = i_evt.cp - PLANE1;
    assign hi_unit = {5'b11011, v[20:10]};
    assign lo_unit = {6'b110111, v[9:0]};

    // next output beat
    always_comb begin
        n_second      = 1'b0;
        n_out.last_unit = 1'b1;
        case (i_evt.kind)
            KIND_REPL: n_out.code_unit = {{(CODE_W-UNIT_W){1'b0}}, i_repl_char};
            KIND_PAIR: begin
                if (r_second) begin
                    n_out.code_unit = {{(CODE_W-UNIT_W){1'b0}}, lo_unit};
                end else begin
                    n_out.code_unit = {{(CODE_W-UNIT_W){1'b0}}, hi_unit};
                    n_out.last_unit = 1'b0;
                    n_second        = 1'b1;
                end
            end
            default:   n_out.code_unit = i_evt.cp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= !i_qstat.empty;
            if (!i_qstat.empty) begin
                r_second <= n_second;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (load && !i_qstat.empty) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule
